[sv/tsf_pkg.sv]
// Shared constants and types for the triangular smoothing filter.
// No dependencies; compiled first.
package tsf_pkg;

  localparam int HALF_WIDTH_DEF = 100;
  localparam int SAMPLE_W       = 8;
  localparam int SAMPLE_MAX     = 255;

  // request codes
  localparam logic ACT_PUSH  = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  // control carried from the window stage to the divide stage
  typedef struct packed {
    logic                raw;
    logic [SAMPLE_W-1:0] raw_val;
    logic                buf_end;
  } tsf_ctl_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_out;
    logic                was_filtered;
    logic                buffer_end;
  } tsf_res_t;

endpackage

[sv/tsf_in_if.sv]
// Request channel of the triangular smoothing filter.
// Depends on nothing; valid/ready handshake with sample payload.
interface tsf_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] sample_in;
  logic       last_sample;

  modport source (output valid, action, sample_in, last_sample, input ready);
  modport sink   (input valid, action, sample_in, last_sample, output ready);
endinterface

[sv/tsf_out_if.sv]
// Result channel of the triangular smoothing filter.
// Depends on nothing; valid/ready handshake with result payload.
interface tsf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample_out;
  logic       was_filtered;
  logic       buffer_end;

  modport source (output valid, sample_out, was_filtered, buffer_end, input ready);
  modport sink   (input valid, sample_out, was_filtered, buffer_end, output ready);
endinterface

[sv/triangular_smoothing_filter.sv]
// Triangular smoothing filter, top level: sample line, running box sums,
// request handling. Depends on tsf_pkg, tsf_in_if, tsf_out_if, tsf_div_stage.
//
//   channel  | dir | handshake   | payload
//   in_bus   | in  | valid/ready | action, sample_in[7:0], last_sample
//   out_bus  | out | valid/ready | sample_out[7:0], was_filtered, buffer_end
//
// One request per cycle unless stalled; results pass p_ctl_r, then o_res_r.
// The triangle sum is kept as a running sum of running box sums, so each push
// is two short add/subtract steps; the divide is one reciprocal multiply.
// A buffer of m < HALF_WIDTH samples is followed by alignment after its last
// sample, during which in_bus.ready is low.
// Reset is synchronous, active low; stalls on out_bus back up into in_bus.
module triangular_smoothing_filter
  import tsf_pkg::*;
#(
  parameter int HALF_WIDTH = HALF_WIDTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  tsf_in_if.sink    in_bus,
  tsf_out_if.source out_bus
);

  localparam int LINE_D = 2 * HALF_WIDTH - 1;
  localparam int SEEN_W = $clog2(LINE_D + 1);
  localparam int HELD_W = $clog2(HALF_WIDTH);
  localparam int S_W    = $clog2(SAMPLE_MAX * HALF_WIDTH + 1);
  localparam int T_W    = $clog2(SAMPLE_MAX * HALF_WIDTH * HALF_WIDTH + 1);

  logic [SAMPLE_W-1:0] xl_r [HALF_WIDTH];
  logic [S_W-1:0]      sl_r [HALF_WIDTH];
  logic [S_W-1:0]      s_r;
  logic [T_W-1:0]      t_r;
  logic [SEEN_W-1:0]   seen_r, seen_nxt;
  logic [HELD_W-1:0]   held_r, held_nxt;
  logic [HELD_W-1:0]   gap_r, gap_nxt;
  logic [HELD_W-1:0]   held_after;
  logic                draining_r, draining_nxt;

  logic                p_valid_r, p_valid_nxt;
  tsf_ctl_t            p_ctl_r;
  logic [T_W-1:0]      p_tsum_r;
  logic                d_ready;
  logic                p_adv;

  logic                in_fire, push_ok, drain_ok, emit_push, emit, align, shift_x;
  logic [SAMPLE_W-1:0] x_in, x_old;
  logic [S_W-1:0]      s_prev, s_old, s_nxt;
  logic [S_W:0]        s_sum;
  logic [T_W-1:0]      t_prev, t_nxt;
  logic [T_W:0]        t_sum;
  logic                have_tail;
  tsf_ctl_t            ctl_nxt;

  assign align    = gap_r != '0;
  assign p_adv    = p_valid_r && d_ready;
  assign in_bus.ready = (!p_valid_r || d_ready) && !align;
  assign in_fire  = in_bus.valid && in_bus.ready;
  assign push_ok  = in_fire && in_bus.action == ACT_PUSH && !draining_r;
  assign drain_ok = in_fire && in_bus.action == ACT_DRAIN && draining_r && held_r != '0;
  assign emit_push = push_ok && seen_r >= SEEN_W'(HALF_WIDTH - 1);
  assign emit     = emit_push || drain_ok;
  assign shift_x  = push_ok || drain_ok || align;
  assign x_in     = push_ok ? in_bus.sample_in : '0;

  // running box sum and triangle sum; history before the buffer counts as zero
  assign have_tail = seen_r >= SEEN_W'(HALF_WIDTH);
  assign x_old  = have_tail ? xl_r[HALF_WIDTH-1] : '0;
  assign s_old  = have_tail ? sl_r[HALF_WIDTH-1] : '0;
  assign s_prev = (seen_r == '0) ? '0 : s_r;
  assign t_prev = (seen_r == '0) ? '0 : t_r;
  assign s_sum  = {1'b0, s_prev} + (S_W+1)'(in_bus.sample_in) - (S_W+1)'(x_old);
  assign s_nxt  = s_sum[S_W-1:0];
  assign t_sum  = {1'b0, t_prev} + (T_W+1)'(s_nxt) - (T_W+1)'(s_old);
  assign t_nxt  = t_sum[T_W-1:0];

  assign held_after = emit_push ? held_r : held_r + HELD_W'(1);

  always_comb begin
    seen_nxt     = seen_r;
    held_nxt     = held_r;
    draining_nxt = draining_r;
    gap_nxt      = gap_r;
    if (push_ok) begin
      if (seen_r != SEEN_W'(LINE_D)) begin
        seen_nxt = seen_r + SEEN_W'(1);
      end
      held_nxt = held_after;
      if (in_bus.last_sample) begin
        draining_nxt = 1'b1;
        gap_nxt      = HELD_W'(HALF_WIDTH - 1) - held_after;
      end
    end else if (drain_ok) begin
      held_nxt = held_r - HELD_W'(1);
      if (held_r == HELD_W'(1)) begin
        draining_nxt = 1'b0;
        seen_nxt     = '0;
      end
    end else if (align) begin
      gap_nxt = gap_r - HELD_W'(1);
    end
  end

  always_comb begin
    ctl_nxt.raw     = drain_ok || in_bus.last_sample || seen_r < SEEN_W'(LINE_D);
    ctl_nxt.raw_val = xl_r[HALF_WIDTH-2];
    ctl_nxt.buf_end = drain_ok && held_r == HELD_W'(1);
    p_valid_nxt     = emit ? 1'b1 : (p_adv ? 1'b0 : p_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= '0;
      held_r     <= '0;
      draining_r <= 1'b0;
      gap_r      <= '0;
      p_valid_r  <= 1'b0;
    end else begin
      seen_r     <= seen_nxt;
      held_r     <= held_nxt;
      draining_r <= draining_nxt;
      gap_r      <= gap_nxt;
      p_valid_r  <= p_valid_nxt;
    end
  end

  // sample line also steps on drain and alignment so the oldest held sample
  // always sits at tap HALF_WIDTH-2
  always_ff @(posedge clk) begin
    if (shift_x) begin
      xl_r[0] <= x_in;
      for (int j = 1; j < HALF_WIDTH; j++) begin
        xl_r[j] <= xl_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      s_r     <= s_nxt;
      t_r     <= t_nxt;
      sl_r[0] <= s_nxt;
      for (int j = 1; j < HALF_WIDTH; j++) begin
        sl_r[j] <= sl_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      p_ctl_r  <= ctl_nxt;
      p_tsum_r <= t_nxt;
    end
  end

  tsf_res_t o_res;

  tsf_div_stage #(
    .HALF_WIDTH (HALF_WIDTH)
  ) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .p_valid     (p_valid_r),
    .p_ctl       (p_ctl_r),
    .p_tsum      (p_tsum_r),
    .stage_ready (d_ready),
    .o_ready     (out_bus.ready),
    .o_valid     (out_bus.valid),
    .o_res       (o_res)
  );

  assign out_bus.sample_out   = o_res.sample_out;
  assign out_bus.was_filtered = o_res.was_filtered;
  assign out_bus.buffer_end   = o_res.buffer_end;

  a_gap_drain: assert property (@(posedge clk) disable iff (!rst_n)
    gap_r != '0 |-> draining_r)
    else $error("alignment outside drain");

  a_held_max: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= HELD_W'(HALF_WIDTH - 1))
    else $error("held count overflow");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> !p_valid_r || p_adv)
    else $error("request overwrote a pending result");

  a_buf_close: assert property (@(posedge clk) disable iff (!rst_n)
    drain_ok && held_r == HELD_W'(1) |=> !draining_r && seen_r == '0 && held_r == '0)
    else $error("buffer not closed after final drain");

endmodule

[sv/tsf_div_stage.sv]
// Output stage: divides the triangle sum by HALF_WIDTH^2 with a reciprocal
// multiply and registers the result. Depends on tsf_pkg.
module tsf_div_stage
  import tsf_pkg::*;
#(
  parameter int HALF_WIDTH = HALF_WIDTH_DEF,
  localparam int T_W = $clog2(SAMPLE_MAX * HALF_WIDTH * HALF_WIDTH + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           p_valid,
  input  tsf_ctl_t       p_ctl,
  input  logic [T_W-1:0] p_tsum,
  output logic           stage_ready,
  input  logic           o_ready,
  output logic           o_valid,
  output tsf_res_t       o_res
);

  localparam int          DIV    = HALF_WIDTH * HALF_WIDTH;
  localparam int          DIV_L  = $clog2(DIV);
  localparam int          SH     = T_W + DIV_L;
  localparam int          M_W    = T_W + 1;
  localparam int          PROD_W = T_W + M_W;
  localparam logic [63:0] POW    = 64'd1 << SH;
  localparam logic [63:0] RECIP  = (POW + 64'(DIV) - 64'd1) / 64'(DIV);

  logic [PROD_W-1:0]   prod;
  logic [SAMPLE_W-1:0] quot;
  logic                o_valid_r;
  tsf_res_t            o_res_r;
  tsf_res_t            o_res_nxt;

  // exact floor division for any T_W-bit dividend
  assign prod = PROD_W'(p_tsum) * PROD_W'(RECIP[M_W-1:0]);
  assign quot = prod[SH +: SAMPLE_W];

  assign stage_ready = !o_valid_r || o_ready;

  always_comb begin
    o_res_nxt.sample_out   = p_ctl.raw ? p_ctl.raw_val : quot;
    o_res_nxt.was_filtered = !p_ctl.raw;
    o_res_nxt.buffer_end   = p_ctl.buf_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (stage_ready) begin
      o_valid_r <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready && p_valid) begin
      o_res_r <= o_res_nxt;
    end
  end

  assign o_valid = o_valid_r;
  assign o_res   = o_res_r;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid_r && !o_ready |=> o_valid_r && $stable(o_res_r))
    else $error("result register changed while stalled");

  a_filt_range: assert property (@(posedge clk) disable iff (!rst_n)
    p_valid && stage_ready && !p_ctl.raw |-> prod[PROD_W-1:SH] == (PROD_W-SH)'(quot))
    else $error("filtered quotient out of sample range");

endmodule
